>>> src/tmab_pkg.sv
// Shared types, codes and field widths of the mesh adjacency builder.
`timescale 1ns / 1ps
package tmab_pkg;

    // Field widths of the channels and of the configuration register
    localparam int CMD_W  = 2;
    localparam int VERT_W = 7;
    localparam int SEL_W  = 2;
    localparam int POS_W  = 7;
    localparam int VAL_W  = 7;
    localparam int STAT_W = 2;
    localparam int CNT_W  = 8;

    // Width of the shared table address fields, wide enough for any legal mesh size
    localparam int IDX_W = 11;

    // Vertex count after reset
    localparam logic [VERT_W-1:0] VCOUNT_RST = 7'd64;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD  = 2'd0,
        CMD_BUILD = 2'd1,
        CMD_READ  = 2'd2
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [SEL_W-1:0] {
        SEL_EDGE  = 2'd0,
        SEL_VFACE = 2'd1,
        SEL_OWNER = 2'd2,
        SEL_ADJ   = 2'd3
    } t_sel;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOAD,
        S_BFS,
        S_BO0,
        S_BO1,
        S_BO2,
        S_BW,
        S_RISS,
        S_RCAP,
        S_RESP
    } t_state;

    // Edge order of the load sequence
    typedef enum logic [2:0] {
        LS_AB,
        LS_BA,
        LS_BC,
        LS_CB,
        LS_CA,
        LS_AC
    } t_lstep;

    // One input beat
    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [VERT_W-1:0] vert_a;
        logic [VERT_W-1:0] vert_b;
        logic [VERT_W-1:0] vert_c;
        logic [SEL_W-1:0]  table_select;
        logic [POS_W-1:0]  row_index;
        logic [POS_W-1:0]  col_index;
    } t_item;

    // One result beat
    typedef struct packed {
        logic [VAL_W-1:0]  value;
        logic [STAT_W-1:0] status;
        logic [CNT_W-1:0]  faces_loaded;
    } t_result;

    // Access request from the sequencer to the table unit
    typedef struct packed {
        logic             edge_we;
        logic             owner_we;
        logic             vf_we;
        logic             fs_we;
        logic             adj_we;
        logic             edge_re;
        logic             vf_re;
        logic             owner_re;
        logic             adj_re;
        logic             fs_re;
        logic [IDX_W-1:0] vrow;
        logic [IDX_W-1:0] vcol;
        logic [IDX_W-1:0] face;
        logic [IDX_W-1:0] fcol;
        logic [IDX_W-1:0] fs_a;
        logic [IDX_W-1:0] fs_b;
        logic [IDX_W-1:0] fs_c;
    } t_tab_cmd;

endpackage

>>> src/tmab_in_if.sv
// Input channel of the mesh adjacency builder.
`timescale 1ns / 1ps
interface tmab_in_if import tmab_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  command;
    logic [VERT_W-1:0] vert_a;
    logic [VERT_W-1:0] vert_b;
    logic [VERT_W-1:0] vert_c;
    logic [SEL_W-1:0]  table_select;
    logic [POS_W-1:0]  row_index;
    logic [POS_W-1:0]  col_index;

    modport source (
        output valid, command, vert_a, vert_b, vert_c, table_select, row_index, col_index,
        input  ready
    );
    modport sink (
        input  valid, command, vert_a, vert_b, vert_c, table_select, row_index, col_index,
        output ready
    );
endinterface

>>> src/tmab_out_if.sv
// Result channel of the mesh adjacency builder.
`timescale 1ns / 1ps
interface tmab_out_if import tmab_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [VAL_W-1:0]  value;
    logic [STAT_W-1:0] status;
    logic [CNT_W-1:0]  faces_loaded;

    modport source (
        output valid, value, status, faces_loaded,
        input  ready
    );
    modport sink (
        input  valid, value, status, faces_loaded,
        output ready
    );
endinterface

>>> src/triangle_mesh_adjacency_builder_core.sv
// Top level of the triangle mesh adjacency builder.
`timescale 1ns / 1ps
// Builds edge map, vertex-face membership, edge owner and face adjacency tables from
// triangles loaded one per beat, and answers one result beat per input beat. All tables
// are held in single-port memories behind one shared access port, so work is serial:
// after the accept a load writes its directed edges one at a time, a read issues the
// table read and then captures the data, and a build fetches each stored face, looks up
// the owners of its edges and marks its neighbors; each then hands over the result. The
// input is not ready while an item is in progress. After reset a clearing pass zeroes
// one entry of every table but the face store per cycle; no input beat is taken until
// it ends, while vertex_count writes are accepted at any time. A finished result waits
// in an output register, so the next beat can be accepted while it is pending.
module triangle_mesh_adjacency_builder_core import tmab_pkg::*; #(
    parameter int MAX_VERTS = 64,
    parameter int MAX_FACES = 128
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    tmab_in_if.sink           i_in,
    tmab_out_if.source        o_out,
    input  logic              i_cfg_we,
    input  logic [VERT_W-1:0] i_cfg_wdata
);

    logic [VERT_W-1:0] r_vcount;
    logic              r_out_valid;
    t_result           r_out;

    t_item             w_item;
    t_tab_cmd          w_tab;
    t_result           w_res;
    logic              w_res_valid;
    logic              w_res_ready;
    logic              w_busy;
    logic              w_ready;
    logic [IDX_W-1:0]  w_fs_a;
    logic [IDX_W-1:0]  w_fs_b;
    logic [IDX_W-1:0]  w_fs_c;
    logic [IDX_W-1:0]  w_owner;
    logic              w_edge;
    logic              w_vf;
    logic              w_adj;

    // Gather the input beat
    assign w_item.command      = i_in.command;
    assign w_item.vert_a       = i_in.vert_a;
    assign w_item.vert_b       = i_in.vert_b;
    assign w_item.vert_c       = i_in.vert_c;
    assign w_item.table_select = i_in.table_select;
    assign w_item.row_index    = i_in.row_index;
    assign w_item.col_index    = i_in.col_index;
    assign i_in.ready          = w_ready;

    // Vertex count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vcount <= VCOUNT_RST;
        end else if (i_cfg_we) begin
            r_vcount <= i_cfg_wdata;
        end
    end

    tmab_seq #(
        .MAX_VERTS (MAX_VERTS),
        .MAX_FACES (MAX_FACES)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (w_item),
        .i_valid     (i_in.valid),
        .o_ready     (w_ready),
        .i_vcount    (r_vcount),
        .i_busy      (w_busy),
        .o_tab       (w_tab),
        .i_fs_a      (w_fs_a),
        .i_fs_b      (w_fs_b),
        .i_fs_c      (w_fs_c),
        .i_owner     (w_owner),
        .i_edge      (w_edge),
        .i_vf        (w_vf),
        .i_adj       (w_adj),
        .o_res_valid (w_res_valid),
        .i_res_ready (w_res_ready),
        .o_res       (w_res)
    );

    tmab_tables #(
        .MAX_VERTS (MAX_VERTS),
        .MAX_FACES (MAX_FACES)
    ) u_tables (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_tab),
        .o_busy  (w_busy),
        .o_fs_a  (w_fs_a),
        .o_fs_b  (w_fs_b),
        .o_fs_c  (w_fs_c),
        .o_owner (w_owner),
        .o_edge  (w_edge),
        .o_vf    (w_vf),
        .o_adj   (w_adj)
    );

    // Output register: take a result when the slot is empty or being drained
    assign w_res_ready = !r_out_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_valid && w_res_ready) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_valid && w_res_ready) begin
            r_out <= w_res;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.value        = r_out.value;
    assign o_out.status       = r_out.status;
    assign o_out.faces_loaded = r_out.faces_loaded;

endmodule

>>> src/tmab_tables.sv
// Connectivity tables with one shared access port and the clearing pass after reset.
`timescale 1ns / 1ps
module tmab_tables import tmab_pkg::*; #(
    parameter int MAX_VERTS = 64,
    parameter int MAX_FACES = 128
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_tab_cmd         i_cmd,
    output logic             o_busy,
    output logic [IDX_W-1:0] o_fs_a,
    output logic [IDX_W-1:0] o_fs_b,
    output logic [IDX_W-1:0] o_fs_c,
    output logic [IDX_W-1:0] o_owner,
    output logic             o_edge,
    output logic             o_vf,
    output logic             o_adj
);

    localparam int VW   = $clog2(MAX_VERTS);
    localparam int FW   = (MAX_FACES > 1) ? $clog2(MAX_FACES) : 1;
    localparam int DIM  = (MAX_VERTS > MAX_FACES) ? MAX_VERTS : MAX_FACES;
    localparam int CW   = $clog2(DIM);

    // Table storage
    logic          r_edge  [MAX_VERTS][MAX_VERTS];
    logic [FW-1:0] r_owner [MAX_VERTS][MAX_VERTS];
    logic          r_vf    [MAX_VERTS][MAX_FACES];
    logic          r_adj   [MAX_FACES][MAX_FACES];
    logic [VW-1:0] r_fs_a  [MAX_FACES];
    logic [VW-1:0] r_fs_b  [MAX_FACES];
    logic [VW-1:0] r_fs_c  [MAX_FACES];

    // Registered read data
    logic          r_edge_q;
    logic [FW-1:0] r_owner_q;
    logic          r_vf_q;
    logic          r_adj_q;
    logic [VW-1:0] r_fs_a_q;
    logic [VW-1:0] r_fs_b_q;
    logic [VW-1:0] r_fs_c_q;

    // Clearing pass state
    logic          r_clr;
    logic [CW-1:0] r_clr_row;
    logic [CW-1:0] r_clr_col;
    logic [CW-1:0] n_clr_row;
    logic [CW-1:0] n_clr_col;
    logic          n_clr;

    logic [VW-1:0] w_vrow;
    logic [VW-1:0] w_vcol;
    logic [FW-1:0] w_face;
    logic [FW-1:0] w_fcol;
    logic [VW-1:0] w_clr_vr;
    logic [VW-1:0] w_clr_vc;
    logic [FW-1:0] w_clr_fr;
    logic [FW-1:0] w_clr_fc;
    logic          w_row_in_v;
    logic          w_row_in_f;
    logic          w_col_in_v;
    logic          w_col_in_f;

    // Trim the shared address fields to the table sizes
    assign w_vrow = i_cmd.vrow[VW-1:0];
    assign w_vcol = i_cmd.vcol[VW-1:0];
    assign w_face = i_cmd.face[FW-1:0];
    assign w_fcol = i_cmd.fcol[FW-1:0];

    assign w_clr_vr   = r_clr_row[VW-1:0];
    assign w_clr_vc   = r_clr_col[VW-1:0];
    assign w_clr_fr   = r_clr_row[FW-1:0];
    assign w_clr_fc   = r_clr_col[FW-1:0];
    assign w_row_in_v = (32'(r_clr_row) < MAX_VERTS);
    assign w_row_in_f = (32'(r_clr_row) < MAX_FACES);
    assign w_col_in_v = (32'(r_clr_col) < MAX_VERTS);
    assign w_col_in_f = (32'(r_clr_col) < MAX_FACES);

    // Advance the clearing sweep, one entry of every table but the face store per cycle
    always_comb begin
        n_clr     = r_clr;
        n_clr_row = r_clr_row;
        n_clr_col = r_clr_col;
        if (r_clr) begin
            if (r_clr_col == CW'(DIM - 1)) begin
                n_clr_col = '0;
                n_clr_row = r_clr_row + CW'(1);
                if (r_clr_row == CW'(DIM - 1)) begin
                    n_clr = 1'b0;
                end
            end else begin
                n_clr_col = r_clr_col + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr     <= 1'b1;
            r_clr_row <= '0;
            r_clr_col <= '0;
        end else begin
            r_clr     <= n_clr;
            r_clr_row <= n_clr_row;
            r_clr_col <= n_clr_col;
        end
    end

    assign o_busy = r_clr;

    // Edge map
    always_ff @(posedge i_clk) begin
        if (r_clr) begin
            if (w_row_in_v && w_col_in_v) begin
                r_edge[w_clr_vr][w_clr_vc] <= 1'b0;
            end
        end else if (i_cmd.edge_we) begin
            r_edge[w_vrow][w_vcol] <= 1'b1;
        end
        if (i_cmd.edge_re) begin
            r_edge_q <= r_edge[w_vrow][w_vcol];
        end
    end

    // Edge owner
    always_ff @(posedge i_clk) begin
        if (r_clr) begin
            if (w_row_in_v && w_col_in_v) begin
                r_owner[w_clr_vr][w_clr_vc] <= '0;
            end
        end else if (i_cmd.owner_we) begin
            r_owner[w_vrow][w_vcol] <= w_face;
        end
        if (i_cmd.owner_re) begin
            r_owner_q <= r_owner[w_vrow][w_vcol];
        end
    end

    // Vertex-face membership
    always_ff @(posedge i_clk) begin
        if (r_clr) begin
            if (w_row_in_v && w_col_in_f) begin
                r_vf[w_clr_vr][w_clr_fc] <= 1'b0;
            end
        end else if (i_cmd.vf_we) begin
            r_vf[w_vrow][w_face] <= 1'b1;
        end
        if (i_cmd.vf_re) begin
            r_vf_q <= r_vf[w_vrow][w_face];
        end
    end

    // Face adjacency
    always_ff @(posedge i_clk) begin
        if (r_clr) begin
            if (w_row_in_f && w_col_in_f) begin
                r_adj[w_clr_fr][w_clr_fc] <= 1'b0;
            end
        end else if (i_cmd.adj_we) begin
            r_adj[w_face][w_fcol] <= 1'b1;
        end
        if (i_cmd.adj_re) begin
            r_adj_q <= r_adj[w_face][w_fcol];
        end
    end

    // Face store, no clearing: only loaded faces are ever read
    always_ff @(posedge i_clk) begin
        if (i_cmd.fs_we) begin
            r_fs_a[w_face] <= i_cmd.fs_a[VW-1:0];
            r_fs_b[w_face] <= i_cmd.fs_b[VW-1:0];
            r_fs_c[w_face] <= i_cmd.fs_c[VW-1:0];
        end
        if (i_cmd.fs_re) begin
            r_fs_a_q <= r_fs_a[w_face];
            r_fs_b_q <= r_fs_b[w_face];
            r_fs_c_q <= r_fs_c[w_face];
        end
    end

    assign o_edge  = r_edge_q;
    assign o_vf    = r_vf_q;
    assign o_adj   = r_adj_q;
    assign o_owner = IDX_W'(r_owner_q);
    assign o_fs_a  = IDX_W'(r_fs_a_q);
    assign o_fs_b  = IDX_W'(r_fs_b_q);
    assign o_fs_c  = IDX_W'(r_fs_c_q);

endmodule

>>> src/tmab_seq.sv
// Command sequencer: decodes a beat and steps the table port through load, build and read.
`timescale 1ns / 1ps
module tmab_seq import tmab_pkg::*; #(
    parameter int MAX_VERTS = 64,
    parameter int MAX_FACES = 128
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_item             i_item,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [VERT_W-1:0] i_vcount,
    input  logic              i_busy,
    output t_tab_cmd          o_tab,
    input  logic [IDX_W-1:0]  i_fs_a,
    input  logic [IDX_W-1:0]  i_fs_b,
    input  logic [IDX_W-1:0]  i_fs_c,
    input  logic [IDX_W-1:0]  i_owner,
    input  logic              i_edge,
    input  logic              i_vf,
    input  logic              i_adj,
    output logic              o_res_valid,
    input  logic              i_res_ready,
    output t_result           o_res
);

    localparam int FCW = $clog2(MAX_FACES + 1);

    t_state           r_state, n_state;
    t_lstep           r_step, n_step;
    t_status          r_status, n_status;
    t_sel             r_sel, n_sel;
    logic [VAL_W-1:0] r_value, n_value;
    logic [IDX_W-1:0] r_a, n_a;
    logic [IDX_W-1:0] r_b, n_b;
    logic [IDX_W-1:0] r_c, n_c;
    logic [IDX_W-1:0] r_row, n_row;
    logic [IDX_W-1:0] r_col, n_col;
    logic [FCW-1:0]   r_face, n_face;
    logic [FCW-1:0]   r_count, n_count;

    logic             w_accept;
    logic [31:0]      w_lim;
    logic             w_verts_ok;
    logic [31:0]      w_rows;
    logic [31:0]      w_cols;
    t_sel             w_sel;

    assign o_ready  = (r_state == S_IDLE) && !i_busy;
    assign w_accept = i_valid && o_ready;
    assign w_sel    = t_sel'(i_item.table_select);

    // Vertex limit is the smaller of the register and the table size
    assign w_lim = (32'(i_vcount) > MAX_VERTS) ? MAX_VERTS : 32'(i_vcount);
    assign w_verts_ok = (i_item.vert_a != '0) && (32'(i_item.vert_a) <= w_lim)
                     && (i_item.vert_b != '0) && (32'(i_item.vert_b) <= w_lim)
                     && (i_item.vert_c != '0) && (32'(i_item.vert_c) <= w_lim);

    // Table dimensions for the read bound check
    assign w_rows = (w_sel == SEL_ADJ) ? MAX_FACES : MAX_VERTS;
    assign w_cols = (w_sel == SEL_VFACE || w_sel == SEL_ADJ) ? MAX_FACES : MAX_VERTS;

    // Next state, table requests and working registers
    always_comb begin
        n_state  = r_state;
        n_step   = r_step;
        n_status = r_status;
        n_sel    = r_sel;
        n_value  = r_value;
        n_a      = r_a;
        n_b      = r_b;
        n_c      = r_c;
        n_row    = r_row;
        n_col    = r_col;
        n_face   = r_face;
        n_count  = r_count;

        o_tab      = '0;
        o_tab.face = IDX_W'(r_count);
        o_tab.fs_a = r_a;
        o_tab.fs_b = r_b;
        o_tab.fs_c = r_c;

        o_res_valid = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_value  = '0;
                    n_status = ST_OK;
                    case (t_cmd'(i_item.command))
                        CMD_LOAD: begin
                            if (!w_verts_ok) begin
                                n_status = ST_RANGE;
                                n_state  = S_RESP;
                            end else if (32'(r_count) >= MAX_FACES) begin
                                n_status = ST_FULL;
                                n_state  = S_RESP;
                            end else begin
                                n_a     = IDX_W'(i_item.vert_a) - IDX_W'(1);
                                n_b     = IDX_W'(i_item.vert_b) - IDX_W'(1);
                                n_c     = IDX_W'(i_item.vert_c) - IDX_W'(1);
                                n_step  = LS_AB;
                                n_state = S_LOAD;
                            end
                        end
                        CMD_BUILD: begin
                            n_face  = '0;
                            n_state = (r_count == '0) ? S_RESP : S_BFS;
                        end
                        CMD_READ: begin
                            if (32'(i_item.row_index) >= w_rows ||
                                32'(i_item.col_index) >= w_cols) begin
                                n_status = ST_RANGE;
                                n_state  = S_RESP;
                            end else begin
                                n_sel   = w_sel;
                                n_row   = IDX_W'(i_item.row_index);
                                n_col   = IDX_W'(i_item.col_index);
                                n_state = S_RISS;
                            end
                        end
                        default: begin
                            n_status = ST_RANGE;
                            n_state  = S_RESP;
                        end
                    endcase
                end
            end

            // Write the six directed edges, owner and membership on every other step
            S_LOAD: begin
                o_tab.edge_we = 1'b1;
                case (r_step)
                    LS_AB: begin
                        o_tab.vrow     = r_a;
                        o_tab.vcol     = r_b;
                        o_tab.owner_we = 1'b1;
                        o_tab.vf_we    = 1'b1;
                        o_tab.fs_we    = 1'b1;
                        n_step         = LS_BA;
                    end
                    LS_BA: begin
                        o_tab.vrow = r_b;
                        o_tab.vcol = r_a;
                        n_step     = LS_BC;
                    end
                    LS_BC: begin
                        o_tab.vrow     = r_b;
                        o_tab.vcol     = r_c;
                        o_tab.owner_we = 1'b1;
                        o_tab.vf_we    = 1'b1;
                        n_step         = LS_CB;
                    end
                    LS_CB: begin
                        o_tab.vrow = r_c;
                        o_tab.vcol = r_b;
                        n_step     = LS_CA;
                    end
                    LS_CA: begin
                        o_tab.vrow     = r_c;
                        o_tab.vcol     = r_a;
                        o_tab.owner_we = 1'b1;
                        o_tab.vf_we    = 1'b1;
                        n_step         = LS_AC;
                    end
                    default: begin
                        o_tab.vrow = r_a;
                        o_tab.vcol = r_c;
                        n_count    = r_count + FCW'(1);
                        n_state    = S_RESP;
                    end
                endcase
            end

            // Fetch the stored face
            S_BFS: begin
                o_tab.face  = IDX_W'(r_face);
                o_tab.fs_re = 1'b1;
                n_state     = S_BO0;
            end

            // Look up owner of b->a
            S_BO0: begin
                o_tab.vrow     = i_fs_b;
                o_tab.vcol     = i_fs_a;
                o_tab.owner_re = 1'b1;
                n_state        = S_BO1;
            end

            // Mark first neighbor, look up owner of c->b
            S_BO1: begin
                o_tab.face     = IDX_W'(r_face);
                o_tab.fcol     = i_owner;
                o_tab.adj_we   = 1'b1;
                o_tab.vrow     = i_fs_c;
                o_tab.vcol     = i_fs_b;
                o_tab.owner_re = 1'b1;
                n_state        = S_BO2;
            end

            // Mark second neighbor, look up owner of a->c
            S_BO2: begin
                o_tab.face     = IDX_W'(r_face);
                o_tab.fcol     = i_owner;
                o_tab.adj_we   = 1'b1;
                o_tab.vrow     = i_fs_a;
                o_tab.vcol     = i_fs_c;
                o_tab.owner_re = 1'b1;
                n_state        = S_BW;
            end

            // Mark third neighbor and advance to the next face, or finish after the last one
            S_BW: begin
                o_tab.face   = IDX_W'(r_face);
                o_tab.fcol   = i_owner;
                o_tab.adj_we = 1'b1;
                n_face       = r_face + FCW'(1);
                n_state      = (r_face == r_count - FCW'(1)) ? S_RESP : S_BFS;
            end

            // Issue the table read
            S_RISS: begin
                case (r_sel)
                    SEL_EDGE: begin
                        o_tab.vrow    = r_row;
                        o_tab.vcol    = r_col;
                        o_tab.edge_re = 1'b1;
                    end
                    SEL_VFACE: begin
                        o_tab.vrow  = r_row;
                        o_tab.face  = r_col;
                        o_tab.vf_re = 1'b1;
                    end
                    SEL_OWNER: begin
                        o_tab.vrow     = r_row;
                        o_tab.vcol     = r_col;
                        o_tab.owner_re = 1'b1;
                    end
                    default: begin
                        o_tab.face   = r_row;
                        o_tab.fcol   = r_col;
                        o_tab.adj_re = 1'b1;
                    end
                endcase
                n_state = S_RCAP;
            end

            // Capture the read data
            S_RCAP: begin
                case (r_sel)
                    SEL_EDGE:  n_value = VAL_W'(i_edge);
                    SEL_VFACE: n_value = VAL_W'(i_vf);
                    SEL_OWNER: n_value = i_owner[VAL_W-1:0];
                    default:   n_value = VAL_W'(i_adj);
                endcase
                n_state = S_RESP;
            end

            // Hand the result beat to the output register
            S_RESP: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_step   <= n_step;
        r_status <= n_status;
        r_sel    <= n_sel;
        r_value  <= n_value;
        r_a      <= n_a;
        r_b      <= n_b;
        r_c      <= n_c;
        r_row    <= n_row;
        r_col    <= n_col;
        r_face   <= n_face;
    end

    assign o_res.value        = r_value;
    assign o_res.status       = r_status;
    assign o_res.faces_loaded = CNT_W'(r_count);

endmodule
